### rtl/tlmm_pkg.sv
// ----------------------------------------------------------------------------
// tlmm_pkg
// shared constants and register codes for the three-level min-max pwm compare
// ----------------------------------------------------------------------------
package tlmm_pkg;

  localparam int VOLT_BITS_DEF = 18;
  localparam int CMP_BITS_DEF  = 15;
  localparam int GAIN_BITS     = 16;
  localparam int CUR_BITS      = 16;
  localparam int RECIP_BITS    = 24;
  localparam int VFRAC         = 8;
  localparam int NORM_FRAC     = 15;
  localparam int PERIOD_RESET  = 5000;

  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BALANCE_GAIN = 8'd0,
    CFG_PWM_PERIOD   = 8'd1
  } cfg_reg_t;

endpackage

### rtl/tlmm_in_if.sv
// ----------------------------------------------------------------------------
// tlmm_in_if
// request channel carrying phase references, dc link and dq quantities
// ----------------------------------------------------------------------------
interface tlmm_in_if #(
  parameter int VOLT_BITS = tlmm_pkg::VOLT_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic signed [VOLT_BITS-1:0]            volt_a;
  logic signed [VOLT_BITS-1:0]            volt_b;
  logic signed [VOLT_BITS-1:0]            volt_c;
  logic        [VOLT_BITS-2:0]            dc_total;
  logic signed [VOLT_BITS-1:0]            dc_difference;
  logic        [tlmm_pkg::RECIP_BITS-1:0] recip_upper;
  logic        [tlmm_pkg::RECIP_BITS-1:0] recip_lower;
  logic signed [VOLT_BITS-1:0]            vdq_d;
  logic signed [VOLT_BITS-1:0]            vdq_q;
  logic signed [tlmm_pkg::CUR_BITS-1:0]   idq_d;
  logic signed [tlmm_pkg::CUR_BITS-1:0]   idq_q;

  modport source (
    output valid, volt_a, volt_b, volt_c, dc_total, dc_difference,
           recip_upper, recip_lower, vdq_d, vdq_q, idq_d, idq_q,
    input  ready
  );
  modport sink (
    input  valid, volt_a, volt_b, volt_c, dc_total, dc_difference,
           recip_upper, recip_lower, vdq_d, vdq_q, idq_d, idq_q,
    output ready
  );
endinterface

### rtl/tlmm_out_if.sv
// ----------------------------------------------------------------------------
// tlmm_out_if
// result channel carrying the six compare values and offset status
// ----------------------------------------------------------------------------
interface tlmm_out_if #(
  parameter int VOLT_BITS = tlmm_pkg::VOLT_BITS_DEF,
  parameter int CMP_BITS  = tlmm_pkg::CMP_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [CMP_BITS-1:0]         cmp_upper_a;
  logic [CMP_BITS-1:0]         cmp_lower_a;
  logic [CMP_BITS-1:0]         cmp_upper_b;
  logic [CMP_BITS-1:0]         cmp_lower_b;
  logic [CMP_BITS-1:0]         cmp_upper_c;
  logic [CMP_BITS-1:0]         cmp_lower_c;
  logic                        overmod_flag;
  logic signed [VOLT_BITS-1:0] common_offset;

  modport source (
    output valid, cmp_upper_a, cmp_lower_a, cmp_upper_b, cmp_lower_b,
           cmp_upper_c, cmp_lower_c, overmod_flag, common_offset,
    input  ready
  );
  modport sink (
    input  valid, cmp_upper_a, cmp_lower_a, cmp_upper_b, cmp_lower_b,
           cmp_upper_c, cmp_lower_c, overmod_flag, common_offset,
    output ready
  );
endinterface

### rtl/tlmm_cfg_if.sv
// ----------------------------------------------------------------------------
// tlmm_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface tlmm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tlmm_pkg::CFG_IDX_BITS-1:0]  index;
  logic [tlmm_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/tlmm_divpipe.sv
// ----------------------------------------------------------------------------
// tlmm_divpipe
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
module tlmm_divpipe #(
  parameter int DEN_W  = 18,
  parameter int NUM_W  = 43,
  parameter int QUO_W  = 25,
  parameter int LANES  = 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num [LANES],
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo [LANES],
  output logic [SIDE_W-1:0] side_out
);
  localparam int RW  = NUM_W - QUO_W;
  localparam int RW1 = RW + 1;

  logic [QUO_W-1:0]  valid_r;
  logic [RW-1:0]     rem_r  [QUO_W][LANES];
  logic [NUM_W-1:0]  num_r  [QUO_W][LANES];
  logic [QUO_W-1:0]  quo_r  [QUO_W][LANES];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [RW-1:0]     rem_src [LANES];
    logic [NUM_W-1:0]  num_src [LANES];
    logic [QUO_W-1:0]  quo_src [LANES];
    logic [DEN_W-1:0]  den_src;
    logic [SIDE_W-1:0] side_src;
    logic              valid_src;
    logic [RW-1:0]     rem_nxt [LANES];
    logic [QUO_W-1:0]  quo_nxt [LANES];

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l] = num[l][NUM_W-1:QUO_W];
          num_src[l] = num[l];
          quo_src[l] = '0;
        end
        den_src   = den;
        side_src  = side_in;
        valid_src = in_valid;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_src[l] = rem_r[s-1][l];
          num_src[l] = num_r[s-1][l];
          quo_src[l] = quo_r[s-1][l];
        end
        den_src   = den_r[s-1];
        side_src  = side_r[s-1];
        valid_src = valid_r[s-1];
      end
    end

    // shift in one numerator bit, subtract when the divisor fits
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW:0] trial;
      logic [RW:0] trial_sub;
      logic        fits;
      always_comb begin
        trial      = {rem_src[l], num_src[l][QUO_W-1-s]};
        trial_sub  = trial - RW1'(den_src);
        fits       = (trial >= RW1'(den_src));
        rem_nxt[l] = fits ? trial_sub[RW-1:0] : trial[RW-1:0];
        quo_nxt[l] = quo_src[l];
        quo_nxt[l][QUO_W-1-s] = fits;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (adv) begin
        valid_r[s] <= valid_src;
      end
      if (adv) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[l];
          num_r[s][l] <= num_src[l];
          quo_r[s][l] <= quo_nxt[l];
        end
        den_r[s]  <= den_src;
        side_r[s] <= side_src;
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign side_out  = side_r[QUO_W-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = quo_r[QUO_W-1][l];
    end
  end
endmodule

### rtl/three_level_minmax_pwm_compare_top.sv
// ----------------------------------------------------------------------------
// three_level_minmax_pwm_compare_top
// the overmodulation divider resolves one quotient bit per stage
// throughput: one request per cycle; a stalled result freezes the whole pipe
// reset: synchronous active-low rst_n clears all valid bits, balance gain 0,
//   pwm period 5000
// ----------------------------------------------------------------------------
module three_level_minmax_pwm_compare_top #(
  parameter int VOLT_BITS = tlmm_pkg::VOLT_BITS_DEF,
  parameter int CMP_BITS  = tlmm_pkg::CMP_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tlmm_in_if.sink   in_chan,
  tlmm_out_if.source out_chan,
  tlmm_cfg_if.sink  cfg_chan
);
  import tlmm_pkg::*;

  localparam int V     = VOLT_BITS;
  localparam int C     = CMP_BITS;
  localparam int RB    = RECIP_BITS;
  localparam int RH    = RB / 2;
  // divider geometry: numerator |v|*dc*2^8, quotient below 2^(V+7)
  localparam int NUM_W = 2 * V + 7;
  localparam int QUO_W = V + 7;
  localparam int LANES = 4;
  // datapath widths
  localparam int REFW  = V + 9;
  localparam int TW    = GAIN_BITS + V + 2;
  localparam int CMW   = V + 10;
  localparam int PW    = V + 11;
  localparam int PRW   = PW + RB + 1;
  localparam int TSH   = VFRAC + RB - NORM_FRAC;
  localparam int TTW   = PRW - TSH;
  localparam int XW    = TTW + C + 1;
  localparam int GSH   = GAIN_BITS - 1 - VFRAC;
  localparam int MARW  = V + 7;
  localparam int GBIAS = (1 << GSH) - 1;
  localparam int VBIAS = (1 << VFRAC) - 1;
  localparam int TBIAS = (1 << TSH) - 1;
  localparam int NBIAS = (1 << NORM_FRAC) - 1;

  // -------------------------------------------------------------- config regs
  logic signed [GAIN_BITS-1:0] gain_r;
  logic        [C-1:0]         period_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= '0;
      period_r <= C'(PERIOD_RESET);
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        CFG_BALANCE_GAIN: gain_r   <= cfg_chan.data[GAIN_BITS-1:0];
        CFG_PWM_PERIOD:   period_r <= cfg_chan.data[C-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- pipe control
  // every stage moves together unless the output register holds an
  // untaken result
  logic out_valid_r;
  logic adv;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // ------------------------------------------------- stage 1: min/max, products
  typedef struct packed {
    logic [2:0][V-1:0]              v;
    logic signed [V:0]              sum;
    logic [V-1:0]                   span;
    logic [V-2:0]                   dc;
    logic signed [V-1:0]            diff;
    logic [RB-1:0]                  ru;
    logic [RB-1:0]                  rl;
    logic signed [V+CUR_BITS-1:0]   pd;
    logic signed [V+CUR_BITS-1:0]   pq;
    logic signed [GAIN_BITS+V-1:0]  gd;
  } s1_t;

  s1_t  s1_r, s1_nxt;
  logic s1_valid_r;

  always_comb begin
    logic signed [V-1:0] mx01, mn01, mx, mn;
    logic signed [V:0]   span_w;
    // largest and smallest phase
    mx01 = (in_chan.volt_a >= in_chan.volt_b) ? in_chan.volt_a : in_chan.volt_b;
    mn01 = (in_chan.volt_a >= in_chan.volt_b) ? in_chan.volt_b : in_chan.volt_a;
    mx   = (in_chan.volt_c > mx01) ? in_chan.volt_c : mx01;
    mn   = (in_chan.volt_c < mn01) ? in_chan.volt_c : mn01;
    span_w = (V+1)'(mx) - (V+1)'(mn);

    s1_nxt.v[0] = in_chan.volt_a;
    s1_nxt.v[1] = in_chan.volt_b;
    s1_nxt.v[2] = in_chan.volt_c;
    s1_nxt.sum  = (V+1)'(mx) + (V+1)'(mn);
    s1_nxt.span = span_w[V-1:0];
    s1_nxt.dc   = in_chan.dc_total;
    s1_nxt.diff = in_chan.dc_difference;
    s1_nxt.ru   = in_chan.recip_upper;
    s1_nxt.rl   = in_chan.recip_lower;
    // dq power terms and the balancing gain product
    s1_nxt.pd   = in_chan.vdq_d * in_chan.idq_d;
    s1_nxt.pq   = in_chan.vdq_q * in_chan.idq_q;
    s1_nxt.gd   = gain_r * in_chan.dc_difference;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_chan.valid;
    end
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // -------------------------------- stage 2: overmod test, divider numerators
  typedef struct packed {
    logic [2:0][V-1:0]              v;
    logic signed [V:0]              sum;
    logic [V-1:0]                   span;
    logic [V-2:0]                   dc;
    logic signed [V-1:0]            diff;
    logic [RB-1:0]                  ru;
    logic [RB-1:0]                  rl;
    logic                           om;
    logic                           pw_neg;
    logic signed [GAIN_BITS+V-1:0]  gd;
    logic [LANES-1:0]               neg;
  } side_t;

  side_t            s2_side;
  logic [NUM_W-1:0] div_num [LANES];

  always_comb begin
    logic signed [V+CUR_BITS:0] pw;
    logic [V-1:0]               absv;
    logic [V:0]                 abssum;
    pw = (V+CUR_BITS+1)'(s1_r.pd) + (V+CUR_BITS+1)'(s1_r.pq);

    s2_side.v      = s1_r.v;
    s2_side.sum    = s1_r.sum;
    s2_side.span   = s1_r.span;
    s2_side.dc     = s1_r.dc;
    s2_side.diff   = s1_r.diff;
    s2_side.ru     = s1_r.ru;
    s2_side.rl     = s1_r.rl;
    s2_side.om     = (s1_r.span > V'(s1_r.dc));
    s2_side.pw_neg = pw[V+CUR_BITS];
    s2_side.gd     = s1_r.gd;

    // magnitudes go through the divider, signs ride alongside
    for (int k = 0; k < 3; k++) begin
      absv = s1_r.v[k][V-1] ? (-s1_r.v[k]) : s1_r.v[k];
      div_num[k] = (NUM_W'(absv) * NUM_W'(s1_r.dc)) << VFRAC;
      s2_side.neg[k] = s1_r.v[k][V-1];
    end
    // common-mode lane: -(max+min)*dc*2^7/span
    abssum = s1_r.sum[V] ? (V+1)'(-s1_r.sum) : (V+1)'(s1_r.sum);
    div_num[3] = (NUM_W'(abssum) * NUM_W'(s1_r.dc)) << (VFRAC - 1);
    s2_side.neg[3] = !s1_r.sum[V] && (s1_r.sum != '0);
  end

  // ------------------------------------------------------ divider stages
  logic                        div_valid;
  logic [QUO_W-1:0]            div_quo [LANES];
  logic [$bits(side_t)-1:0]    div_side_vec;
  side_t                       sd;

  tlmm_divpipe #(
    .DEN_W  (V),
    .NUM_W  (NUM_W),
    .QUO_W  (QUO_W),
    .LANES  (LANES),
    .SIDE_W ($bits(side_t))
  ) u_divpipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s1_valid_r),
    .num       (div_num),
    .den       (s1_r.span),
    .side_in   (s2_side),
    .out_valid (div_valid),
    .quo       (div_quo),
    .side_out  (div_side_vec)
  );

  assign sd = side_t'(div_side_vec);

  // ----------------------------- stage A: references, balancing offset clamp
  logic                   sa_valid_r;
  logic signed [REFW-1:0] ref_r [3];
  logic signed [REFW-1:0] ref_nxt [3];
  logic signed [CMW-1:0]  cm_r, cm_nxt;
  logic                   sa_om_r;
  logic [RB-1:0]          sa_ru_r, sa_rl_r;

  always_comb begin
    logic signed [REFW-1:0] qv, cm0;
    logic signed [TW-1:0]   t, t_b, tq, voff, mar_s, vclamp;
    logic [MARW-1:0]        mar;
    for (int k = 0; k < 3; k++) begin
      qv = REFW'(div_quo[k]);
      if (sd.om) begin
        ref_nxt[k] = sd.neg[k] ? -qv : qv;
      end else begin
        ref_nxt[k] = REFW'($signed(sd.v[k])) <<< VFRAC;
      end
    end
    qv = REFW'(div_quo[3]);
    if (sd.om) begin
      cm0 = sd.neg[3] ? -qv : qv;
    end else begin
      cm0 = -(REFW'(sd.sum) <<< (VFRAC - 1));
    end

    // gain*diff*sign(power), truncated toward zero, plus diff/2
    t     = sd.pw_neg ? -TW'(sd.gd) : TW'(sd.gd);
    t_b   = t[TW-1] ? t + TW'(GBIAS) : t;
    tq    = t_b >>> GSH;
    voff  = tq + (TW'(sd.diff) <<< (VFRAC - 1));
    // half the remaining margin; zero once the span was scaled to dc
    mar   = sd.om ? '0 : (MARW'(sd.dc) - MARW'(sd.span)) << (VFRAC - 1);
    mar_s = TW'(mar);
    if (voff > mar_s) begin
      vclamp = mar_s;
    end else if (voff < -mar_s) begin
      vclamp = -mar_s;
    end else begin
      vclamp = voff;
    end
    cm_nxt = CMW'(cm0) + CMW'(vclamp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (adv) begin
      sa_valid_r <= div_valid;
    end
    if (adv) begin
      ref_r   <= ref_nxt;
      cm_r    <= cm_nxt;
      sa_om_r <= sd.om;
      sa_ru_r <= sd.ru;
      sa_rl_r <= sd.rl;
    end
  end

  // --------------------------- stage B: pole voltages, reciprocal select
  logic                  sb_valid_r;
  logic signed [PW-1:0]  pole_r [3];
  logic signed [PW-1:0]  pole_nxt [3];
  logic [RB-1:0]         recip_r [3];
  logic [RB-1:0]         recip_nxt [3];
  logic signed [V-1:0]   sb_co_r, co_nxt;
  logic                  sb_om_r;

  always_comb begin
    logic signed [CMW-1:0] c_b, cq, co_hi, co_lo;
    for (int k = 0; k < 3; k++) begin
      pole_nxt[k]  = PW'(ref_r[k]) + PW'(cm_r);
      recip_nxt[k] = pole_nxt[k][PW-1] ? sa_rl_r : sa_ru_r;
    end
    // total offset back in input lsb, saturated to the voltage range
    c_b   = cm_r[CMW-1] ? cm_r + CMW'(VBIAS) : cm_r;
    cq    = c_b >>> VFRAC;
    co_hi = {{(CMW-V+1){1'b0}}, {(V-1){1'b1}}};
    co_lo = ~co_hi;
    if (cq > co_hi) begin
      co_nxt = co_hi[V-1:0];
    end else if (cq < co_lo) begin
      co_nxt = co_lo[V-1:0];
    end else begin
      co_nxt = cq[V-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
    end else if (adv) begin
      sb_valid_r <= sa_valid_r;
    end
    if (adv) begin
      pole_r  <= pole_nxt;
      recip_r <= recip_nxt;
      sb_co_r <= co_nxt;
      sb_om_r <= sa_om_r;
    end
  end

  // ---------------------- stage C: pole times reciprocal, two partial products
  logic                          sc_valid_r;
  logic signed [PW+RH:0]         plo_r [3];
  logic signed [PW+RB-RH:0]      phi_r [3];
  logic signed [V-1:0]           sc_co_r;
  logic                          sc_om_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (adv) begin
      sc_valid_r <= sb_valid_r;
    end
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= pole_r[k] * $signed({1'b0, recip_r[k][RH-1:0]});
        phi_r[k] <= pole_r[k] * $signed({1'b0, recip_r[k][RB-1:RH]});
      end
      sc_co_r <= sb_co_r;
      sc_om_r <= sb_om_r;
    end
  end

  // ------------------------- stage D: combine, truncate to normalized duty
  logic                   sd_valid_r;
  logic signed [TTW-1:0]  duty_r [3];
  logic signed [TTW-1:0]  duty_nxt [3];
  logic signed [V-1:0]    sd_co_r;
  logic                   sd_om_r;

  always_comb begin
    logic signed [PRW-1:0] prod, p_b, psh;
    for (int k = 0; k < 3; k++) begin
      prod = (PRW'(phi_r[k]) <<< RH) + PRW'(plo_r[k]);
      p_b  = prod[PRW-1] ? prod + PRW'(TBIAS) : prod;
      psh  = p_b >>> TSH;
      duty_nxt[k] = psh[TTW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_valid_r <= 1'b0;
    end else if (adv) begin
      sd_valid_r <= sc_valid_r;
    end
    if (adv) begin
      duty_r  <= duty_nxt;
      sd_co_r <= sc_co_r;
      sd_om_r <= sc_om_r;
    end
  end

  // ------------------------------------------ stage E: duty times period
  logic                  se_valid_r;
  logic signed [XW-1:0]  tick_r [3];
  logic signed [V-1:0]   se_co_r;
  logic                  se_om_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      se_valid_r <= 1'b0;
    end else if (adv) begin
      se_valid_r <= sd_valid_r;
    end
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        tick_r[k] <= XW'(duty_r[k]) * XW'($signed({1'b0, period_r}));
      end
      se_co_r <= sd_co_r;
      se_om_r <= sd_om_r;
    end
  end

  // ---------------------------- output register: whole ticks and clamps
  logic [C-1:0]        up_r [3];
  logic [C-1:0]        lo_r [3];
  logic [C-1:0]        up_nxt [3];
  logic [C-1:0]        lo_nxt [3];
  logic signed [V-1:0] co_r;
  logic                om_r;

  always_comb begin
    logic signed [XW-1:0] x_b, xq, perx, y;
    perx = XW'($signed({1'b0, period_r}));
    for (int k = 0; k < 3; k++) begin
      x_b = tick_r[k][XW-1] ? tick_r[k] + XW'(NBIAS) : tick_r[k];
      xq  = x_b >>> NORM_FRAC;
      y   = xq + perx;
      // upper compare clamp(x, 0, P), lower compare clamp(P + x, 0, P)
      if (xq > perx) begin
        up_nxt[k] = period_r;
      end else if (xq[XW-1]) begin
        up_nxt[k] = '0;
      end else begin
        up_nxt[k] = xq[C-1:0];
      end
      if (y > perx) begin
        lo_nxt[k] = period_r;
      end else if (y[XW-1]) begin
        lo_nxt[k] = '0;
      end else begin
        lo_nxt[k] = y[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= se_valid_r;
    end
    if (adv) begin
      up_r <= up_nxt;
      lo_r <= lo_nxt;
      co_r <= se_co_r;
      om_r <= se_om_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.cmp_upper_a   = up_r[0];
  assign out_chan.cmp_lower_a   = lo_r[0];
  assign out_chan.cmp_upper_b   = up_r[1];
  assign out_chan.cmp_lower_b   = lo_r[1];
  assign out_chan.cmp_upper_c   = up_r[2];
  assign out_chan.cmp_lower_c   = lo_r[2];
  assign out_chan.overmod_flag  = om_r;
  assign out_chan.common_offset = co_r;

endmodule

### dv/tlmm_compare_monitor.sv
// ----------------------------------------------------------------------------
// tlmm_compare_monitor
// watches the request, result and register channels, predicts the six
// compare values, overmodulation flag and common offset, and compares them
// ----------------------------------------------------------------------------
module tlmm_compare_monitor (
  input  logic clk,
  input  logic rst_n,
  tlmm_in_if   in_mon,
  tlmm_out_if  out_mon,
  tlmm_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  import tlmm_pkg::*;

  typedef struct {
    longint upper_a, lower_a, upper_b, lower_b, upper_c, lower_c;
    longint overmod, offset;
  } compare_set_t;

  compare_set_t expected_q[$];
  longint gain_q15;
  longint period_ticks;

  function automatic longint clip(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // pole voltage in q.8 to signed carrier ticks
  function automatic longint pole_ticks(longint pole, longint ru, longint rl, longint per);
    longint r, t;
    r = (pole >= 0) ? ru : rl;
    t = (pole * r) / 64'sd131072;
    return (t * per) / 64'sd32768;
  endfunction

  function automatic compare_set_t predict_compares();
    compare_set_t res;
    longint v[3], ref8[3], cmp_u[3], cmp_l[3];
    longint dc, diff, ru, rl, mx, mn, span, sum, cm, amp8, pw, voff, mar, x;
    dc   = longint'(in_mon.dc_total);
    diff = longint'(in_mon.dc_difference);
    ru   = longint'(in_mon.recip_upper);
    rl   = longint'(in_mon.recip_lower);
    v[0] = longint'(in_mon.volt_a);
    v[1] = longint'(in_mon.volt_b);
    v[2] = longint'(in_mon.volt_c);
    mx = (v[0] >= v[1]) ? v[0] : v[1];
    mn = (v[0] >= v[1]) ? v[1] : v[0];
    if (v[2] > mx) mx = v[2];
    if (v[2] < mn) mn = v[2];
    span = mx - mn;
    sum  = mx + mn;
    res.overmod = (span > dc);
    if (span > dc) begin
      for (int k = 0; k < 3; k++) ref8[k] = (v[k] * dc * 256) / span;
      cm   = (-sum * dc * 128) / span;
      amp8 = dc * 256;
    end else begin
      for (int k = 0; k < 3; k++) ref8[k] = v[k] * 256;
      cm   = -sum * 128;
      amp8 = span * 256;
    end
    pw = longint'(in_mon.vdq_d) * longint'(in_mon.idq_d)
       + longint'(in_mon.vdq_q) * longint'(in_mon.idq_q);
    // neutral point balancing, sign follows power flow
    voff = (gain_q15 * diff * ((pw >= 0) ? 1 : -1)) / 128 + diff * 128;
    mar  = (dc * 256 - amp8) / 2;
    cm  += clip(voff, -mar, mar);
    for (int k = 0; k < 3; k++) begin
      x = pole_ticks(ref8[k] + cm, ru, rl, period_ticks);
      cmp_u[k] = clip(x, 0, period_ticks);
      cmp_l[k] = clip(period_ticks + x, 0, period_ticks);
    end
    res.upper_a = cmp_u[0]; res.lower_a = cmp_l[0];
    res.upper_b = cmp_u[1]; res.lower_b = cmp_l[1];
    res.upper_c = cmp_u[2]; res.lower_c = cmp_l[2];
    res.offset  = clip(cm / 256, -131072, 131071);
    return res;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    compare_set_t e;
    if (!rst_n) begin
      gain_q15     = 0;
      period_ticks = PERIOD_RESET;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == CFG_BALANCE_GAIN)
          gain_q15 = longint'($signed(cfg_mon.data));
        else if (cfg_mon.index == CFG_PWM_PERIOD)
          period_ticks = longint'(cfg_mon.data[14:0]);
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(predict_compares());
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got upper_a %0d", $time,
                   out_mon.cmp_upper_a);
        end else begin
          e = expected_q.pop_front();
          check_field("cmp_upper_a", e.upper_a, longint'(out_mon.cmp_upper_a));
          check_field("cmp_lower_a", e.lower_a, longint'(out_mon.cmp_lower_a));
          check_field("cmp_upper_b", e.upper_b, longint'(out_mon.cmp_upper_b));
          check_field("cmp_lower_b", e.lower_b, longint'(out_mon.cmp_lower_b));
          check_field("cmp_upper_c", e.upper_c, longint'(out_mon.cmp_upper_c));
          check_field("cmp_lower_c", e.lower_c, longint'(out_mon.cmp_lower_c));
          check_field("overmod_flag", e.overmod, longint'(out_mon.overmod_flag));
          check_field("common_offset", e.offset, longint'(out_mon.common_offset));
        end
      end
      pending = expected_q.size();
    end
  end
endmodule

### dv/three_level_minmax_pwm_compare_top_tb.sv
// ----------------------------------------------------------------------------
// three_level_minmax_pwm_compare_top_tb
// drives directed and random phase references through several gain and
// period settings with random idling on both channels; the monitor predicts
// and compares every result, this module gives the verdict
// ----------------------------------------------------------------------------
module three_level_minmax_pwm_compare_top_tb;
  import tlmm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 40;
  localparam int V           = VOLT_BITS_DEF;

  typedef struct {
    int va, vb, vc, dc, diff, ru, rl, vd, vq, id, iq;
  } pwm_request_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles;
  bit   quiet;   // no idling in the final stretch

  tlmm_in_if  in_chan ();
  tlmm_out_if out_chan ();
  tlmm_cfg_if cfg_chan ();

  three_level_minmax_pwm_compare_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  tlmm_compare_monitor u_monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("three_level_minmax_pwm_compare_top_tb: errors");
        $finish;
      end
    end
  end

  // result side stalls in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet) begin
        out_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // one request, held until accepted, then maybe an idle burst
  task automatic send_request(pwm_request_t r);
    in_chan.valid         <= 1'b1;
    in_chan.volt_a        <= V'(r.va);
    in_chan.volt_b        <= V'(r.vb);
    in_chan.volt_c        <= V'(r.vc);
    in_chan.dc_total      <= (V-1)'(r.dc);
    in_chan.dc_difference <= V'(r.diff);
    in_chan.recip_upper   <= RECIP_BITS'(r.ru);
    in_chan.recip_lower   <= RECIP_BITS'(r.rl);
    in_chan.vdq_d         <= V'(r.vd);
    in_chan.vdq_q         <= V'(r.vq);
    in_chan.idq_d         <= CUR_BITS'(r.id);
    in_chan.idq_q         <= CUR_BITS'(r.iq);
    do @(posedge clk); while (!in_chan.ready);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  // lower valid and wait until every result is back plus the pipe latency
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic pwm_request_t random_request();
    pwm_request_t r;
    int mode, amp;
    mode = $urandom_range(0, 9);
    r.dc = (mode < 2) ? $urandom_range(0, 131071) : $urandom_range(1000, 131071);
    if (mode == 0) begin
      // full range noise, lots of overmodulation
      r.va   = $urandom_range(0, 262143) - 131072;
      r.vb   = $urandom_range(0, 262143) - 131072;
      r.vc   = $urandom_range(0, 262143) - 131072;
      r.diff = $urandom_range(0, 262143) - 131072;
      r.ru   = $urandom_range(0, 16777215);
      r.rl   = $urandom_range(0, 16777215);
    end else begin
      // realistic operating point, sometimes pushed into overmodulation
      amp    = (mode == 1) ? r.dc : (r.dc * 6) / 10;
      r.va   = $urandom_range(0, 2 * amp) - amp;
      r.vb   = $urandom_range(0, 2 * amp) - amp;
      r.vc   = $urandom_range(0, 2 * amp) - amp;
      r.diff = $urandom_range(0, r.dc / 10) - r.dc / 20;
      r.ru   = 33554432 / (r.dc + 1) + $urandom_range(0, 255);
      r.rl   = 33554432 / (r.dc + 1) + $urandom_range(0, 255);
    end
    r.vd = $urandom_range(0, 262143) - 131072;
    r.vq = $urandom_range(0, 262143) - 131072;
    r.id = $urandom_range(0, 65535) - 32768;
    r.iq = $urandom_range(0, 65535) - 32768;
    return r;
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_request(random_request());
  endtask

  function automatic pwm_request_t make_request(int va, int vb, int vc, int dc, int diff,
                                                int ru, int rl, int vd, int vq,
                                                int id, int iq);
    pwm_request_t r;
    r.va = va; r.vb = vb; r.vc = vc; r.dc = dc; r.diff = diff;
    r.ru = ru; r.rl = rl; r.vd = vd; r.vq = vq; r.id = id; r.iq = iq;
    return r;
  endfunction

  initial begin
    quiet          = 0;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.volt_a = '0; in_chan.volt_b = '0; in_chan.volt_c = '0;
    in_chan.dc_total = '0; in_chan.dc_difference = '0;
    in_chan.recip_upper = '0; in_chan.recip_lower = '0;
    in_chan.vdq_d = '0; in_chan.vdq_q = '0; in_chan.idq_d = '0; in_chan.idq_q = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_BALANCE_GAIN;
    cfg_chan.data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset period, with a nonzero gain
    write_reg(CFG_BALANCE_GAIN, 16'h4000);
    // all zero: zero pole voltage, zero power
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // balanced set inside the link
    send_request(make_request(8000, -4000, -4000, 32000, 1000, 1048, 1048, 100, 0, 50, 0));
    // negative power flips the balancing sign
    send_request(make_request(8000, -4000, -4000, 32000, 1000, 1048, 1048, 100, 0, -50, 0));
    // span exceeds link: overmodulation scaling
    send_request(make_request(131071, -131072, 0, 20000, -3000, 1677, 1677,
                              -131072, 131071, 32767, -32768));
    // extremes of every field
    send_request(make_request(131071, 131071, 131071, 131071, 131071, 16777215, 16777215,
                              131071, 131071, 32767, 32767));
    send_request(make_request(-131072, -131072, -131072, 131071, -131072, 16777215, 0,
                              -131072, -131072, -32768, -32768));
    // large offset saturates the common offset
    send_request(make_request(-131072, -131072, -131072, 131071, 0, 100, 100, 0, 0, 0, 0));
    send_request(make_request(131071, 131071, 131071, 131071, 0, 100, 100, 0, 0, 0, 0));
    // large compare clamped rather than wrapped
    send_request(make_request(100000, -100000, 0, 131071, 0, 16777215, 16777215,
                              0, 0, 0, 0));
    // zero link voltage with nonzero references
    send_request(make_request(5, -5, 0, 0, 7, 9999, 9999, 1, 1, 1, 1));
    // lower reciprocal only for negative poles
    send_request(make_request(-20000, -10000, 30000, 100000, 0, 0, 16777215, 3, -3, 3, 3));
    drain();

    // settings sweep including extremes, unknown index ignored
    write_reg(CFG_BALANCE_GAIN, 16'h7fff);
    write_reg(CFG_PWM_PERIOD, 16'h7fff);
    write_reg(cfg_reg_t'(8'd2), 16'h1234);
    random_phase(400);
    drain();

    write_reg(CFG_BALANCE_GAIN, 16'h8000);
    write_reg(CFG_PWM_PERIOD, 16'd1);
    random_phase(300);
    drain();

    // zero period: both compares stay at zero
    write_reg(CFG_PWM_PERIOD, 16'h8000);
    write_reg(CFG_BALANCE_GAIN, 16'hffff);
    random_phase(200);
    drain();

    write_reg(CFG_BALANCE_GAIN, 16'($urandom_range(0, 65535)));
    write_reg(CFG_PWM_PERIOD, 16'($urandom_range(0, 65535)));
    random_phase(400);
    drain();

    write_reg(CFG_BALANCE_GAIN, 16'h2000);
    write_reg(CFG_PWM_PERIOD, 16'd5000);
    random_phase(500);
    // final stretch without idling
    quiet = 1;
    random_phase(200);
    drain();

    if (fail_count == 0)
      $display("three_level_minmax_pwm_compare_top_tb: clean");
    else
      $display("three_level_minmax_pwm_compare_top_tb: errors");
    $finish;
  end
endmodule

### sim.f
rtl/tlmm_pkg.sv
rtl/tlmm_in_if.sv
rtl/tlmm_out_if.sv
rtl/tlmm_cfg_if.sv
rtl/tlmm_divpipe.sv
rtl/three_level_minmax_pwm_compare_top.sv
dv/tlmm_compare_monitor.sv
dv/three_level_minmax_pwm_compare_top_tb.sv
